[sv/bbf_pkg.sv]
// bbf_pkg: shared types and constants for the box blur filter.
// Word layouts, register codes, sequencer states and default sizes.
// No dependencies.
`default_nettype none

package bbf_pkg;

    localparam int MAX_RADIUS_DEF = 8;
    localparam int MAX_WIDTH_DEF  = 1024;

    localparam logic [3:0]  RADIUS_RST = 4'd1;
    localparam logic [10:0] WIDTH_RST  = 11'd900;
    localparam logic [15:0] HEIGHT_RST = 16'd900;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2,
        REG_NONE   = 2'd3
    } t_reg;

    typedef enum logic [0:0] {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_PX,
        S_ACC,
        S_LAST,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       frame_end;
    } t_out_word;

endpackage

`default_nettype wire

[sv/bbf_ram.sv]
// bbf_ram: generic single-clock RAM, one write and one read port.
// Read data is registered. No dependencies.
`default_nettype none

module bbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/box_blur_filter_top.sv]
// box_blur_filter_top: streaming box blur over RGBA pixels in raster order.
// Uses bbf_pkg and one bbf_ram instance as the pixel ring.
//
//  channel | valid       | stall       | word        | accepted when
//  in      | i_in_valid  | o_in_stall  | i_in_data   | valid & !stall
//  out     | o_out_valid | i_out_stall | o_out_data  | valid & !stall
//  cfg     | psel        | penable     | paddr/pwdata| psel&penable&pwrite
//
// A word that releases no output leaves the sequencer in S_IDLE; a border or
// pass-through pixel runs through S_CENTER, S_PX and S_OUT; an interior pixel
// takes 4*r*r ring reads (one per cycle through the single RAM read port) plus
// 8 divide steps in S_ACC, S_LAST and S_DIV. Reset is synchronous and clears
// control state only; the ring is not cleared. The input stalls after reset
// and after each register write while derived sizes settle. The result sits
// in an output register, so a stalled output blocks only the next result.
`default_nettype none

module box_blur_filter_top
    import bbf_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_word    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_word        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RING = 2 * MAX_RADIUS * MAX_WIDTH;
    localparam int AW   = $clog2(RING);
    localparam int PW   = AW + 1;
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = $clog2(4 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int SW   = 8 + CW;
    localparam int NW   = (2 * MAX_RADIUS > 1) ? $clog2(2 * MAX_RADIUS) : 1;

    // configuration
    logic [3:0]  r_radius;
    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [RW-1:0] r_er;
    logic [WW-1:0] r_ew;
    logic [15:0]   r_eh;
    logic [PW-1:0] r_delay;
    logic [AW-1:0] r_rw;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_end;
    logic [1:0]    r_cfg_wait;

    t_reg  cfg_reg;
    logic  cfg_wr;

    assign pready  = 1'b1;
    assign cfg_reg = t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_reg)
            REG_RADIUS: prdata = {28'd0, r_radius};
            REG_WIDTH:  prdata = {21'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_reg)
                REG_RADIUS: r_radius <= pwdata[3:0];
                REG_WIDTH:  r_width  <= pwdata[10:0];
                REG_HEIGHT: r_height <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    // hold the input off until the two derived levels below have settled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wait <= 2'd2;
        end else if (cfg_wr) begin
            r_cfg_wait <= 2'd2;
        end else if (r_cfg_wait != 2'd0) begin
            r_cfg_wait <= r_cfg_wait - 2'd1;
        end
    end

    // effective sizes and derived constants, two register levels
    always_ff @(posedge i_clk) begin
        if (int'(r_radius) > MAX_RADIUS) r_er <= RW'(MAX_RADIUS);
        else r_er <= RW'(r_radius);
        if (r_width == 11'd0) r_ew <= WW'(1);
        else if (int'(r_width) > MAX_WIDTH) r_ew <= WW'(MAX_WIDTH);
        else r_ew <= WW'(r_width);
        r_eh <= (r_height == 16'd0) ? 16'd1 : r_height;
        if (r_er == '0) r_delay <= '0;
        else r_delay <= PW'((PW'(r_er) - PW'(1)) * PW'(r_ew) + PW'(r_er) - PW'(1));
        r_rw  <= AW'(PW'(r_er) * PW'(r_ew) + PW'(r_er));
        r_cnt <= CW'(CW'(r_er) * CW'(r_er) * CW'(4));
        r_end <= NW'({1'b0, r_er, 1'b0} - (RW + 2)'(1));
    end

    // datapath state
    t_state r_state, n_state;
    logic [AW-1:0] r_wr_ptr;
    logic [PW-1:0] r_pending;
    logic [AW-1:0] r_base, r_addr, r_row_start;
    logic [15:0]   r_orow;
    logic [WW-1:0] r_ocol;
    logic [31:0]   r_px;
    logic [NW-1:0] r_m, r_n;
    logic          r_rd_vld;
    logic [2:0][SW-1:0] r_sum;
    logic [2:0][7:0]    r_q;
    logic [2:0]    r_bit;
    logic          r_ovld;
    t_out_word     r_odata;

    logic          acc, emit, interior, out_free, last_pix;
    logic [AW-1:0] base, start, raddr;
    logic [31:0]   rdata;
    logic [AW:0]   wr_ext, row_nxt;
    logic [PW-1:0] pend_inc;

    assign acc      = i_in_valid && (r_state == S_IDLE) && (r_cfg_wait == 2'd0);
    assign pend_inc = r_pending + PW'(1);
    assign emit     = (i_in_data.cmd == CMD_DRAIN) ? (r_pending != '0) : (pend_inc > r_delay);
    assign out_free = !r_ovld || !i_out_stall;
    assign wr_ext   = {1'b0, r_wr_ptr};

    assign o_in_stall  = (r_state != S_IDLE) || (r_cfg_wait != 2'd0);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

    always_comb begin
        if (wr_ext >= r_pending) base = AW'(wr_ext - r_pending);
        else base = AW'(wr_ext + (AW + 1)'(RING) - r_pending);
        if (r_base >= r_rw) start = r_base - r_rw;
        else start = AW'({1'b0, r_base} + (AW + 1)'(RING) - {1'b0, r_rw});
        row_nxt = {1'b0, r_row_start} + (AW + 1)'(r_ew);
        if (row_nxt >= (AW + 1)'(RING)) row_nxt = row_nxt - (AW + 1)'(RING);
        interior = (r_er != '0) && (r_orow >= 16'(r_er))
                && ({1'b0, r_orow} + 17'(r_er) < {1'b0, r_eh})
                && (r_ocol >= WW'(r_er))
                && ({1'b0, r_ocol} + (WW + 1)'(r_er) < {1'b0, r_ew});
        last_pix = ({1'b0, r_orow} + 17'd1 >= {1'b0, r_eh})
                && ({1'b0, r_ocol} + (WW + 1)'(1) >= {1'b0, r_ew});
        raddr = (r_state == S_CENTER) ? r_base : r_addr;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (acc && emit) n_state = S_CENTER;
            S_CENTER: n_state = S_PX;
            S_PX:     n_state = interior ? S_ACC : S_OUT;
            S_ACC:    if (r_m == r_end && r_n == r_end) n_state = S_LAST;
            S_LAST:   n_state = S_DIV;
            S_DIV:    if (r_bit == 3'd0) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    bbf_ram #(.WIDTH(32), .DEPTH(RING)) u_ring (
        .i_clk   (i_clk),
        .i_we    (acc && (i_in_data.cmd == CMD_PIXEL)),
        .i_waddr (r_wr_ptr),
        .i_wdata ({i_in_data.alpha_in, i_in_data.blue_in, i_in_data.green_in,
                   i_in_data.red_in}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_pending <= '0;
            r_orow    <= '0;
            r_ocol    <= '0;
            r_ovld    <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_ACC);
            if (acc && (i_in_data.cmd == CMD_PIXEL)) begin
                r_wr_ptr  <= (r_wr_ptr == AW'(RING - 1)) ? '0 : r_wr_ptr + AW'(1);
                r_pending <= pend_inc;
            end
            if (r_ovld && !i_out_stall) r_ovld <= 1'b0;
            if (r_state == S_OUT && out_free) begin
                r_ovld    <= 1'b1;
                r_pending <= r_pending - PW'(1);
                if ({1'b0, r_ocol} + (WW + 1)'(1) >= {1'b0, r_ew}) begin
                    r_ocol <= '0;
                    if ({1'b0, r_orow} + 17'd1 >= {1'b0, r_eh}) r_orow <= '0;
                    else r_orow <= r_orow + 16'd1;
                end else begin
                    r_ocol <= r_ocol + WW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_base <= base;
        if (r_rd_vld) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SW'(rdata[8*c +: 8]);
            end
        end
        case (r_state)
            S_PX: begin
                r_px        <= rdata;
                r_addr      <= start;
                r_row_start <= start;
                r_m         <= '0;
                r_n         <= '0;
                r_sum       <= '0;
                for (int c = 0; c < 3; c++) r_q[c] <= rdata[8*c +: 8];
            end
            S_ACC: begin
                if (r_m == r_end) begin
                    r_m         <= '0;
                    r_n         <= r_n + NW'(1);
                    r_row_start <= AW'(row_nxt);
                    r_addr      <= AW'(row_nxt);
                end else begin
                    r_m    <= r_m + NW'(1);
                    r_addr <= (r_addr == AW'(RING - 1)) ? '0 : r_addr + AW'(1);
                end
            end
            S_LAST: begin
                r_bit <= 3'd7;
                r_q   <= '0;
            end
            S_DIV: begin
                r_bit <= r_bit - 3'd1;
                for (int c = 0; c < 3; c++) begin
                    if (r_sum[c] >= (SW'(r_cnt) << r_bit)) begin
                        r_sum[c]       <= r_sum[c] - (SW'(r_cnt) << r_bit);
                        r_q[c][r_bit]  <= 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_odata.red_out   <= r_q[0];
                    r_odata.green_out <= r_q[1];
                    r_odata.blue_out  <= r_q[2];
                    r_odata.alpha_out <= r_px[31:24];
                    r_odata.frame_end <= last_pix;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[sim/box_blur_filter_top_tb.sv]
// box_blur_filter_top_tb: self-checking bench for the streaming box blur filter.
// Holds a pixel-ring predictor and checks every output word in order; uses bbf_pkg.
// Drives pixel/drain words, APB register writes, random gaps and output stalls.
`default_nettype none

module box_blur_filter_top_tb
    import bbf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 2 * MAX_RADIUS_DEF * MAX_WIDTH_DEF;
    localparam int SETTLE     = 300;
    localparam int LIMIT      = 3000000;

    class blur_scoreboard;
        bit [31:0] ring [RING_DEPTH];
        int wr_ptr, in_row, in_col, out_row, out_col, pending;
        int radius = 1, width = 900, height = 900;
        t_out_word expq [$];
        int errors, n_pixels, n_drains, n_checked, n_blurred;

        function int eff_r();
            return radius > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : radius;
        endfunction

        function int eff_w();
            if (width == 0) return 1;
            return width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width;
        endfunction

        function int eff_h();
            return height == 0 ? 1 : height;
        endfunction

        function bit step_pos(ref int row, ref int col);
            bit last;
            last = (row + 1 >= eff_h()) && (col + 1 >= eff_w());
            col++;
            if (col >= eff_w()) begin
                col = 0;
                row++;
                if (row >= eff_h()) row = 0;
            end
            return last;
        endfunction

        function void set_reg(t_reg idx, int v);
            case (idx)
                REG_RADIUS: radius = v & 'hF;
                REG_WIDTH:  width  = v & 'h7FF;
                REG_HEIGHT: height = v & 'hFFFF;
                default: ;
            endcase
        endfunction

        function t_out_word blur_pixel();
            int r, w, h, base, pos, sr, sg, sb, cnt;
            bit [31:0] px, q;
            t_out_word o;
            r = eff_r();
            w = eff_w();
            h = eff_h();
            base = (wr_ptr + RING_DEPTH - pending) % RING_DEPTH;
            px = ring[base];
            o.red_out   = px[7:0];
            o.green_out = px[15:8];
            o.blue_out  = px[23:16];
            o.alpha_out = px[31:24];
            if (r > 0 && out_row >= r && out_row + r < h && out_col >= r && out_col + r < w) begin
                sr = 0; sg = 0; sb = 0;
                cnt = 4 * r * r;
                for (int n = -r; n < r; n++) begin
                    for (int m = -r; m < r; m++) begin
                        pos = (base + 2 * RING_DEPTH + n * w + m) % RING_DEPTH;
                        q = ring[pos];
                        sr += q[7:0];
                        sg += q[15:8];
                        sb += q[23:16];
                    end
                end
                o.red_out   = 8'(sr / cnt);
                o.green_out = 8'(sg / cnt);
                o.blue_out  = 8'(sb / cnt);
                n_blurred++;
            end
            o.frame_end = step_pos(out_row, out_col);
            pending--;
            return o;
        endfunction

        function void note_input(t_in_word d);
            int r, delay;
            if (d.cmd == CMD_DRAIN) begin
                if (pending > 0) begin
                    n_drains++;
                    expq.push_back(blur_pixel());
                end
                return;
            end
            n_pixels++;
            ring[wr_ptr] = {d.alpha_in, d.blue_in, d.green_in, d.red_in};
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            void'(step_pos(in_row, in_col));
            pending++;
            r = eff_r();
            delay = (r == 0) ? 0 : (r - 1) * eff_w() + (r - 1);
            if (pending > delay) expq.push_back(blur_pixel());
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word exp_w;
            if (expq.size() == 0) begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            exp_w = expq.pop_front();
            n_checked++;
            if (got.red_out != exp_w.red_out)
                report($sformatf("red %h, want %h", got.red_out, exp_w.red_out));
            if (got.green_out != exp_w.green_out)
                report($sformatf("green %h, want %h", got.green_out, exp_w.green_out));
            if (got.blue_out != exp_w.blue_out)
                report($sformatf("blue %h, want %h", got.blue_out, exp_w.blue_out));
            if (got.alpha_out != exp_w.alpha_out)
                report($sformatf("alpha %h, want %h", got.alpha_out, exp_w.alpha_out));
            if (got.frame_end != exp_w.frame_end)
                report($sformatf("frame_end %b, want %b", got.frame_end, exp_w.frame_end));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    blur_scoreboard sb = new();
    int cycles;
    int stall_pct;
    int hold_req, hold_seen, hold_left;
    bit no_gaps;
    int n_phases;

    box_blur_filter_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // receiver: random stalls, occasional long hold-offs
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 599) == 0) begin
            hold_left <= $urandom_range(20, 80);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic int pick_gap();
        int v;
        if (no_gaps) return 0;
        v = $urandom_range(0, 99);
        if (v < 65) return 0;
        if (v < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
    endtask

    task automatic cfg_write(t_reg idx, int v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // pattern: 0 random, 1 alternating all-zero / all-one pixels
    task automatic run_frames(int r, int w, int h, int frames, int pattern, int max_px);
        t_in_word d;
        int npx;
        wait_idle();
        cfg_write(REG_RADIUS, r);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        n_phases++;
        npx = sb.eff_w() * sb.eff_h();
        if (max_px > 0 && npx > max_px) npx = max_px;
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 2) == 0) begin
                d = t_in_word'({$urandom(), 1'b0});
                d.cmd = CMD_DRAIN;
                send_word(d);
            end
            for (int k = 0; k < npx; k++) begin
                d = t_in_word'({$urandom(), 1'b0});
                if (pattern == 1) d = (k % 2) ? '1 : '0;
                d.cmd = CMD_PIXEL;
                send_word(d);
            end
            while (sb.pending > 0) begin
                d = t_in_word'({$urandom(), 1'b0});
                d.cmd = CMD_DRAIN;
                send_word(d);
            end
        end
    endtask

    initial begin
        int r, re, w, h, v;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stall_pct = 0;
        no_gaps = 1'b1;
        run_frames(0, 0, 0, 2, 1, 0);
        run_frames(1, 4, 4, 1, 1, 0);

        // long output hold-off while pixels keep coming
        stall_pct = 10;
        hold_req++;
        run_frames(1, 12, 10, 1, 0, 0);

        while (sb.n_pixels + sb.n_drains < 250) begin
            v = $urandom_range(0, 99);
            if (v < 40) r = $urandom_range(0, 2);
            else if (v < 85) r = $urandom_range(3, 5);
            else if (v < 97) r = $urandom_range(6, 8);
            else r = $urandom_range(9, 15);
            re = (r > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : r;
            w = $urandom_range(0, 2 * re + 8);
            h = $urandom_range(0, 2 * re + 6);
            if (w > 0 && w * h > 120) h = 120 / w;
            stall_pct = $urandom_range(0, 3) * 20;
            no_gaps = ($urandom_range(0, 3) == 0);
            run_frames(r, w, h, $urandom_range(1, 2), 0, 0);
        end

        stall_pct = 20;
        no_gaps = 1'b0;
        run_frames(8, 17, 17, 1, 0, 0);
        run_frames(15, 2047, 1, 1, 0, 40);
        run_frames(1, 1, 65535, 1, 0, 40);

        wait_idle();
        if (sb.expq.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.expq.size()));
        $display("covered %0d register settings: %0d pixels, %0d drains", n_phases,
                 sb.n_pixels, sb.n_drains);
        $display("checked %0d output words, %0d of them blurred", sb.n_checked, sb.n_blurred);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
